### rtl/pdav_pkg.sv
package pdav_pkg;

    // adler-32 modulus
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // config port
    localparam int          ADDR_W         = 2;
    localparam logic [1:0]  ADDR_FLAG_BIT  = 2'd0;

    // result kind codes
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       payload;
        logic [3:0] hdr_idx;
        logic       short_end;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] packet_id;
        logic [15:0] error_code;
        logic [15:0] flag_word;
        logic [31:0] checksum_received;
        logic [31:0] checksum_computed;
        logic        legal;
        logic [15:0] payload_length;
        logic        short_packet;
        logic        end_of_run;
    } t_result;

endpackage

### rtl/pdav_fifo.sv
module pdav_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/pdav_front.sv
module pdav_front #(
    parameter int HDR_LEN = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    output logic          o_full,
    output logic          o_cmd_push,
    output pdav_pkg::t_cmd o_cmd,
    input  logic          i_cmd_full
);

    import pdav_pkg::*;

    localparam logic [3:0] HDR_END = 4'(HDR_LEN);

    logic [3:0] r_pos, n_pos;
    logic       accept;
    logic       in_hdr;

    assign o_full     = i_cmd_full;
    assign accept     = i_push && !i_cmd_full;
    assign o_cmd_push = accept;
    assign in_hdr     = (r_pos != HDR_END);

    // classify the incoming byte
    always_comb begin
        o_cmd.data_byte = i_data_byte;
        o_cmd.last      = i_last;
        o_cmd.payload   = !in_hdr;
        o_cmd.hdr_idx   = r_pos;
        o_cmd.short_end = i_last && in_hdr && (r_pos != HDR_END - 4'd1);
    end

    // header position, held at the header end during payload
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_last) begin
                n_pos = '0;
            end else if (in_hdr) begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

### rtl/pdav_back.sv
module pdav_back #(
    parameter int ID_BYTES    = 4,
    parameter int ERROR_BYTES = 2,
    parameter int FLAG_BYTES  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_flag_bit,
    input  pdav_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output logic              o_res_push,
    output pdav_pkg::t_result o_res,
    input  logic              i_res_full
);

    import pdav_pkg::*;

    localparam logic [3:0] ERR_BASE = 4'(ID_BYTES);
    localparam logic [3:0] FLG_BASE = 4'(ID_BYTES + ERROR_BYTES);
    localparam logic [3:0] SUM_BASE = 4'(ID_BYTES + ERROR_BYTES + FLAG_BYTES);

    logic [3:0][7:0] r_id, n_id;
    logic [1:0][7:0] r_err, n_err;
    logic [1:0][7:0] r_flags, n_flags;
    logic [3:0][7:0] r_stored, n_stored;
    logic [15:0]     r_lo, n_lo;
    logic [15:0]     r_hi, n_hi;
    logic [15:0]     r_count, n_count;
    logic            r_short, n_short;
    logic            r_pend, n_pend;

    logic [16:0]     lo_sum, hi_sum;
    logic [15:0]     lo_new, hi_new;
    logic [3:0]      off;
    logic [31:0]     computed;
    logic [15:0]     err_word;
    logic            want;

    // adler update, two adds each with one conditional subtract
    always_comb begin
        lo_sum = {1'b0, r_lo} + {9'b0, i_cmd.data_byte};
        lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
        hi_sum = {1'b0, r_hi} + {1'b0, lo_new};
        hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
    end

    // summary fields from the packet state
    always_comb begin
        computed = {r_hi, r_lo};
        want     = r_flags[i_flag_bit[3]][i_flag_bit[2:0]];
        if (ERROR_BYTES < 2) begin
            err_word = {{8{r_err[0][7]}}, r_err[0]};
        end else begin
            err_word = r_err;
        end
    end

    // sequencing: one command a cycle if queues allow; pending summary first
    always_comb begin
        n_id       = r_id;
        n_err      = r_err;
        n_flags    = r_flags;
        n_stored   = r_stored;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_count    = r_count;
        n_short    = r_short;
        n_pend     = r_pend;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        off        = '0;
        o_res      = '0;

        if (r_pend) begin
            if (!i_res_full) begin
                o_res_push              = 1'b1;
                o_res.kind              = KIND_SUMMARY;
                o_res.packet_id         = r_id;
                o_res.error_code        = err_word;
                o_res.flag_word         = r_flags;
                o_res.checksum_received = r_stored;
                o_res.checksum_computed = computed;
                o_res.legal             = !r_short && !(want && (computed != r_stored));
                o_res.payload_length    = r_count;
                o_res.short_packet      = r_short;
                o_res.end_of_run        = 1'b1;
                n_id     = '0;
                n_err    = '0;
                n_flags  = '0;
                n_stored = '0;
                n_lo     = 16'd1;
                n_hi     = '0;
                n_count  = '0;
                n_short  = 1'b0;
                n_pend   = 1'b0;
            end
        end else if (!i_cmd_empty && !i_res_full) begin
            o_cmd_pop = 1'b1;
            if (i_cmd.payload) begin
                n_lo    = lo_new;
                n_hi    = hi_new;
                n_count = (r_count != 16'hFFFF) ? r_count + 16'd1 : r_count;
                o_res_push         = 1'b1;
                o_res.kind         = KIND_PAYLOAD;
                o_res.payload_byte = i_cmd.data_byte;
                o_res.end_of_run   = !i_cmd.last;
            end else begin
                priority if (i_cmd.hdr_idx < ERR_BASE) begin
                    off = i_cmd.hdr_idx;
                    n_id[off[1:0]] = i_cmd.data_byte;
                end else if (i_cmd.hdr_idx < FLG_BASE) begin
                    off = i_cmd.hdr_idx - ERR_BASE;
                    n_err[off[0]] = i_cmd.data_byte;
                end else if (i_cmd.hdr_idx < SUM_BASE) begin
                    off = i_cmd.hdr_idx - FLG_BASE;
                    n_flags[off[0]] = i_cmd.data_byte;
                end else begin
                    off = i_cmd.hdr_idx - SUM_BASE;
                    n_stored[off[1:0]] = i_cmd.data_byte;
                end
            end
            if (i_cmd.last) begin
                n_pend  = 1'b1;
                n_short = i_cmd.short_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id     <= '0;
            r_err    <= '0;
            r_flags  <= '0;
            r_stored <= '0;
            r_lo     <= 16'd1;
            r_hi     <= '0;
            r_count  <= '0;
            r_short  <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_id     <= n_id;
            r_err    <= n_err;
            r_flags  <= n_flags;
            r_stored <= n_stored;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_count  <= n_count;
            r_short  <= n_short;
            r_pend   <= n_pend;
        end
    end

endmodule

### rtl/packet_deframe_adler_verify.sv
// channel   direction  handshake            payload
// ------------------------------------------------------------------------------
// input     in         push / full          i_data_byte, i_last
// result    out        empty / pop          o_kind .. o_end_of_run (11 fields)
// config    in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// the back end handles each byte, header or payload, in turn, and after the last byte of a
// packet it builds the summary item before it takes the next byte.
// reset is synchronous on i_rst_n low; it clears the queues, the packet state and
// the flag bit register. a byte queue and a result queue (four items each) let
// the input side and the result side stall independently; the back end waits
// while the result queue is full.
module packet_deframe_adler_verify #(
    parameter int ID_BYTES       = 4,
    parameter int ERROR_BYTES    = 2,
    parameter int FLAG_BYTES     = 2,
    parameter int CHECKSUM_BYTES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_kind,
    output logic [7:0]                  o_payload_byte,
    output logic [31:0]                 o_packet_id,
    output logic signed [15:0]          o_error_code,
    output logic [15:0]                 o_flag_word,
    output logic [31:0]                 o_checksum_received,
    output logic [31:0]                 o_checksum_computed,
    output logic                        o_legal,
    output logic [15:0]                 o_payload_length,
    output logic                        o_short_packet,
    output logic                        o_end_of_run,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdav_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import pdav_pkg::*;

    localparam int HDR_LEN   = ID_BYTES + ERROR_BYTES + FLAG_BYTES + CHECKSUM_BYTES;
    localparam int Q_DEPTH   = 4;

    logic [3:0] r_flag_bit, n_flag_bit;
    logic       cfg_wr;

    t_cmd       cmd_in, cmd_out;
    logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
    t_result    res_in, res_out;
    logic       res_push, res_full;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_FLAG_BIT);
    assign n_flag_bit = cfg_wr ? pwdata[3:0] : r_flag_bit;
    assign prdata = (paddr == ADDR_FLAG_BIT) ? {28'b0, r_flag_bit} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_bit <= '0;
        end else begin
            r_flag_bit <= n_flag_bit;
        end
    end

    // byte classification
    pdav_front #(
        .HDR_LEN (HDR_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_full      (full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full)
    );

    // queue between front and back
    pdav_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // header assembly, adler and summary
    pdav_back #(
        .ID_BYTES    (ID_BYTES),
        .ERROR_BYTES (ERROR_BYTES),
        .FLAG_BYTES  (FLAG_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flag_bit  (r_flag_bit),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    // result queue
    pdav_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    // result fields
    assign o_kind              = res_out.kind;
    assign o_payload_byte      = res_out.payload_byte;
    assign o_packet_id         = res_out.packet_id;
    assign o_error_code        = $signed(res_out.error_code);
    assign o_flag_word         = res_out.flag_word;
    assign o_checksum_received = res_out.checksum_received;
    assign o_checksum_computed = res_out.checksum_computed;
    assign o_legal             = res_out.legal;
    assign o_payload_length    = res_out.payload_length;
    assign o_short_packet      = res_out.short_packet;
    assign o_end_of_run        = res_out.end_of_run;

endmodule

### tb/sv/tb_top.sv
module tb_top;

    import pdav_pkg::*;

    // header layout of the block under test
    localparam int ID_BYTES       = 4;
    localparam int ERROR_BYTES    = 2;
    localparam int FLAG_BYTES     = 2;
    localparam int CHECKSUM_BYTES = 4;
    localparam int HDR_BYTES      = ID_BYTES + ERROR_BYTES + FLAG_BYTES + CHECKSUM_BYTES;

    localparam int LIMIT_CYCLES   = 1000000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS    = 340;

    // how the stored checksum of a generated packet relates to the payload
    typedef enum int {SUM_MATCH, SUM_BAD, SUM_RANDOM} t_sum_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_link_byte;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [7:0]           i_data_byte;
    logic                 i_last;
    logic                 empty;
    logic                 pop;
    logic                 o_kind;
    logic [7:0]           o_payload_byte;
    logic [31:0]          o_packet_id;
    logic signed [15:0]   o_error_code;
    logic [15:0]          o_flag_word;
    logic [31:0]          o_checksum_received;
    logic [31:0]          o_checksum_computed;
    logic                 o_legal;
    logic [15:0]          o_payload_length;
    logic                 o_short_packet;
    logic                 o_end_of_run;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // stimulus and scoreboard storage
    t_link_byte link_bytes[$];
    t_result    pending_results[$];
    t_link_byte next_byte;
    t_result    want_result;

    // deframer shadow state
    logic [3:0]  flag_sel;
    logic [3:0]  hdr_pos;
    logic [31:0] id_acc;
    logic [15:0] err_acc;
    logic [15:0] flags_acc;
    logic [31:0] stored_acc;
    logic [31:0] adler_sum;
    logic [15:0] pay_len;

    int  mismatches;
    int  cycle_count;
    int  send_gap;
    int  stall_left;
    int  holdoff_req;
    int  holdoff_taken;

    packet_deframe_adler_verify #(
        .ID_BYTES       (ID_BYTES),
        .ERROR_BYTES    (ERROR_BYTES),
        .FLAG_BYTES     (FLAG_BYTES),
        .CHECKSUM_BYTES (CHECKSUM_BYTES)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_data_byte         (i_data_byte),
        .i_last              (i_last),
        .empty               (empty),
        .pop                 (pop),
        .o_kind              (o_kind),
        .o_payload_byte      (o_payload_byte),
        .o_packet_id         (o_packet_id),
        .o_error_code        (o_error_code),
        .o_flag_word         (o_flag_word),
        .o_checksum_received (o_checksum_received),
        .o_checksum_computed (o_checksum_computed),
        .o_legal             (o_legal),
        .o_payload_length    (o_payload_length),
        .o_short_packet      (o_short_packet),
        .o_end_of_run        (o_end_of_run),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // one adler-32 step, sum packed as {high, low}
    function automatic logic [31:0] adler_next(input logic [31:0] s, input logic [7:0] b);
        logic [16:0] lo;
        logic [16:0] hi;
        lo = {1'b0, s[15:0]} + {9'd0, b};
        if (lo >= ADLER_MOD) lo = lo - ADLER_MOD;
        hi = {1'b0, s[31:16]} + lo;
        if (hi >= ADLER_MOD) hi = hi - ADLER_MOD;
        return {hi[15:0], lo[15:0]};
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 24);
    endfunction

    task automatic clear_packet_state();
        hdr_pos    = '0;
        id_acc     = '0;
        err_acc    = '0;
        flags_acc  = '0;
        stored_acc = '0;
        adler_sum  = 32'd1;
        pay_len    = '0;
    endtask

    // expected results of one accepted byte
    task automatic deframe_byte(input logic [7:0] b, input logic is_last);
        t_result r;
        logic    is_short;
        logic    verify;
        if (hdr_pos < HDR_BYTES) begin
            if (hdr_pos < ID_BYTES) begin
                id_acc[hdr_pos*8 +: 8] = b;
            end else if (hdr_pos < ID_BYTES + ERROR_BYTES) begin
                err_acc[(hdr_pos-ID_BYTES)*8 +: 8] = b;
            end else if (hdr_pos < ID_BYTES + ERROR_BYTES + FLAG_BYTES) begin
                flags_acc[(hdr_pos-ID_BYTES-ERROR_BYTES)*8 +: 8] = b;
            end else begin
                stored_acc[(hdr_pos-ID_BYTES-ERROR_BYTES-FLAG_BYTES)*8 +: 8] = b;
            end
            hdr_pos = hdr_pos + 4'd1;
        end else begin
            adler_sum = adler_next(adler_sum, b);
            if (pay_len != 16'hffff) pay_len = pay_len + 16'd1;
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.end_of_run = !is_last;
            pending_results.push_back(r);
        end
        // end of packet summary
        if (is_last) begin
            is_short = (hdr_pos < HDR_BYTES);
            verify = flags_acc[flag_sel];
            r = '0;
            r.kind = KIND_SUMMARY;
            r.packet_id = id_acc;
            r.error_code = err_acc;
            r.flag_word = flags_acc;
            r.checksum_received = stored_acc;
            r.checksum_computed = adler_sum;
            r.legal = !is_short && !(verify && adler_sum != stored_acc);
            r.payload_length = pay_len;
            r.short_packet = is_short;
            r.end_of_run = 1'b1;
            pending_results.push_back(r);
            clear_packet_state();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) deframe_byte(i_data_byte, i_last);
            if (push && full) begin
                // item still offered, hold it
            end else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (link_bytes.size() != 0) begin
                next_byte = link_bytes.pop_front();
                push <= 1'b1;
                i_data_byte <= next_byte.data_byte;
                i_last <= next_byte.last;
                send_gap = pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("result item with nothing expected, kind %0d", o_kind);
                    mismatches++;
                end else begin
                    want_result = pending_results.pop_front();
                    check_field("kind", want_result.kind, o_kind);
                    check_field("payload_byte", want_result.payload_byte, o_payload_byte);
                    check_field("packet_id", want_result.packet_id, o_packet_id);
                    check_field("error_code", {16'd0, want_result.error_code},
                                {16'd0, o_error_code});
                    check_field("flag_word", want_result.flag_word, o_flag_word);
                    check_field("checksum_received", want_result.checksum_received,
                                o_checksum_received);
                    check_field("checksum_computed", want_result.checksum_computed,
                                o_checksum_computed);
                    check_field("legal", want_result.legal, o_legal);
                    check_field("payload_length", want_result.payload_length,
                                o_payload_length);
                    check_field("short_packet", want_result.short_packet, o_short_packet);
                    check_field("end_of_run", want_result.end_of_run, o_end_of_run);
                end
            end
            // long hold-off so the block backs up and raises full
            if (holdoff_req != holdoff_taken) begin
                holdoff_taken = holdoff_req;
                stall_left = HOLDOFF_CYCLES;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // register write then read back
    task automatic write_flag_bit(input logic [3:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_FLAG_BIT;
        pwdata <= {28'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        flag_sel = v;
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[3:0] !== v) begin
            $error("checksum_flag_bit: expected 0x%0h, actual 0x%0h", v, prdata[3:0]);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every item went in and every result came out
    task automatic wait_drained();
        do @(posedge i_clk);
        while (link_bytes.size() != 0 || push || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // full packet: header, then payload, last on the final byte
    task automatic queue_packet(input logic [31:0] id, input logic [15:0] err,
                                input logic [15:0] flags, input t_sum_mode mode,
                                input int n_payload, input int fill);
        logic [7:0]  body[$];
        logic [7:0]  b;
        logic [31:0] adler;
        logic [31:0] stored;
        logic [95:0] hdr_bits;
        t_link_byte  item;
        int          k;
        adler = 32'd1;
        for (k = 0; k < n_payload; k++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            body.push_back(b);
            adler = adler_next(adler, b);
        end
        case (mode)
            SUM_MATCH: stored = adler;
            SUM_BAD:   stored = adler ^ (32'($urandom) | 32'd1);
            default:   stored = $urandom;
        endcase
        hdr_bits = {stored, flags, err, id};
        for (k = 0; k < HDR_BYTES; k++) begin
            item.data_byte = hdr_bits[k*8 +: 8];
            item.last = (n_payload == 0) && (k == HDR_BYTES - 1);
            link_bytes.push_back(item);
        end
        for (k = 0; k < n_payload; k++) begin
            item.data_byte = body[k];
            item.last = (k == n_payload - 1);
            link_bytes.push_back(item);
        end
    endtask

    // packet cut off inside the header
    task automatic queue_short(input int n);
        t_link_byte item;
        int         k;
        for (k = 0; k < n; k++) begin
            item.data_byte = 8'($urandom);
            item.last = (k == n - 1);
            link_bytes.push_back(item);
        end
    endtask

    // random mix of packets, mostly well formed
    task automatic queue_random_traffic(input int budget);
        int          queued;
        int          r;
        int          n;
        logic [15:0] flags;
        t_sum_mode   mode;
        queued = 0;
        while (queued < budget) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                n = $urandom_range(1, HDR_BYTES - 1);
                queue_short(n);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) n = 0;
                else if (r < 95) n = $urandom_range(1, 40);
                else n = $urandom_range(41, 300);
                flags = 16'($urandom);
                flags[flag_sel] = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 99);
                if (r < 50) mode = SUM_MATCH;
                else if (r < 85) mode = SUM_BAD;
                else mode = SUM_RANDOM;
                queue_packet($urandom, 16'($urandom), flags, mode, n, -1);
                n = n + HDR_BYTES;
            end
            queued += n;
        end
    endtask

    // reset, directed packets, random phases
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_data_byte = '0;
        i_last = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        flag_sel = '0;
        clear_packet_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short, header only, bad sum with and without the check flag
        write_flag_bit(4'd0);
        queue_short(1);
        queue_packet(32'h0000_0000, 16'h7fff, 16'h0001, SUM_MATCH, 0, -1);
        queue_packet(32'hffff_ffff, 16'h8000, 16'hffff, SUM_BAD, 2, 255);
        queue_packet(32'h0000_0000, 16'h0000, 16'hfffe, SUM_BAD, 1, 0);
        wait_drained();

        write_flag_bit(4'd15);
        holdoff_req++;
        queue_random_traffic(PHASE_ITEMS);
        wait_drained();

        write_flag_bit(4'($urandom_range(1, 14)));
        queue_random_traffic(PHASE_ITEMS);
        wait_drained();

        write_flag_bit(4'd0);
        holdoff_req++;
        queue_random_traffic(PHASE_ITEMS);
        wait_drained();

        write_flag_bit(4'($urandom_range(1, 14)));
        queue_random_traffic(PHASE_ITEMS);
        wait_drained();

        write_flag_bit(4'd7);
        queue_random_traffic(PHASE_ITEMS);
        wait_drained();

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
